FILE: hdl/bmm_pkg.sv
// shared types and constants for the bipartite matching block
`default_nettype none

package bmm_pkg;

    // fixed field widths
    localparam int ROW_W = 64;
    localparam int CNT_W = 7;

    // right_count after reset
    localparam logic [CNT_W-1:0] RIGHT_COUNT_RESET = 7'd64;

    // one input item: adjacency row of the next left vertex
    typedef struct packed {
        logic [ROW_W-1:0] row_bits;
        logic             last_row;
    } row_item_t;

    // one result item
    typedef struct packed {
        logic [CNT_W-1:0] match_count;
        logic             overflow;
    } res_item_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;     // take the row, start a new search
        logic read_adj;   // read adjacency row of the current vertex
        logic take_edge;  // mark the picked right vertex as seen
        logic claim;      // picked right vertex is free: match it, count it
        logic push;       // picked right vertex is taken: push frame, read its partner
        logic follow;     // move to the partner, read its row
        logic pop_read;   // read the top stack frame, drop the depth
        logic pop_take;   // back up to the popped left vertex, read its row
        logic unwind_wr;  // rewrite one partner along the augmenting path
        logic emit;       // load the result register and clear the graph
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic row_ok;     // room left for another row
        logic last_pend;  // current item closes the graph
        logic cand_any;   // some unseen neighbor remains
        logic cand_free;  // the picked neighbor is unmatched
        logic depth_zero; // search stack is empty
        logic res_busy;   // result register holds an item not taken this cycle
    } sts_t;

endpackage

`default_nettype wire

FILE: hdl/bmm_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic                   re,
    input  wire logic [AW-1:0]          raddr,
    output logic      [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bmm_ctrl.sv
// controller state machine sequencing the augmenting search
`default_nettype none

module bmm_ctrl
    import bmm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic row_valid,
    output logic      row_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_LOAD   = 7'b0000010,
        ST_PICK   = 7'b0000100,
        ST_FOLLOW = 7'b0001000,
        ST_POP    = 7'b0010000,
        ST_UNWIND = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign row_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (row_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.row_ok ? ST_LOAD : ST_FINISH;
                end
            end
            ST_LOAD:
            begin
                cmd.read_adj = 1'b1;
                state_next   = ST_PICK;
            end
            ST_PICK:
            begin
                if (!sts.cand_any)
                begin
                    // dead end: back up or give up
                    if (sts.depth_zero)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.pop_read = 1'b1;
                        state_next   = ST_POP;
                    end
                end
                else
                begin
                    cmd.take_edge = 1'b1;
                    if (sts.cand_free)
                    begin
                        // path found: match the free vertex, then flip the path
                        cmd.claim = 1'b1;
                        if (sts.depth_zero)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.pop_read = 1'b1;
                            state_next   = ST_UNWIND;
                        end
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        state_next = ST_FOLLOW;
                    end
                end
            end
            ST_FOLLOW:
            begin
                cmd.follow = 1'b1;
                state_next = ST_PICK;
            end
            ST_POP:
            begin
                cmd.pop_take = 1'b1;
                state_next   = ST_PICK;
            end
            ST_UNWIND:
            begin
                cmd.unwind_wr = 1'b1;
                if (sts.depth_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.pop_read = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!sts.last_pend)
                begin
                    state_next = ST_IDLE;
                end
                else if (!sts.res_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bmm_datapath.sv
// datapath: adjacency, partner and stack memories, seen marks, counters, result register
`default_nettype none

module bmm_datapath
    import bmm_pkg::*;
#(
    parameter int LEFT_MAX  = 64,
    parameter int RIGHT_MAX = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    input  wire logic [CNT_W-1:0] cfg_data,
    input  wire row_item_t        row_item,
    input  wire cmd_t             cmd,
    output sts_t                  sts,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output res_item_t             res_item
);

    localparam int LW  = (LEFT_MAX > 1) ? $clog2(LEFT_MAX) : 1;
    localparam int RW  = (RIGHT_MAX > 1) ? $clog2(RIGHT_MAX) : 1;
    localparam int RLW = $clog2(LEFT_MAX + 1);
    localparam int DW  = $clog2(RIGHT_MAX + 1);
    localparam int SW  = LW + RW;

    logic [RIGHT_MAX-1:0] mask_reg,    mask_next;
    logic [RLW-1:0]       rows_reg,    rows_next;
    logic [LW-1:0]        cur_reg,     cur_next;
    logic [DW-1:0]        depth_reg,   depth_next;
    logic [RIGHT_MAX-1:0] visited_reg, visited_next;
    logic [RIGHT_MAX-1:0] pvalid_reg,  pvalid_next;
    logic [CNT_W-1:0]     matched_reg, matched_next;
    logic                 ovf_reg,     ovf_next;
    logic                 last_reg,    last_next;
    logic                 res_valid_reg, res_valid_next;
    res_item_t            res_item_reg;

    logic [RIGHT_MAX-1:0] adj_rdata;
    logic [LW-1:0]        adj_raddr;
    logic [LW-1:0]        part_rdata;
    logic                 part_we;
    logic [RW-1:0]        part_waddr;
    logic [LW-1:0]        part_wdata;
    logic [SW-1:0]        stk_rdata;
    logic [LW-1:0]        stk_left;
    logic [RW-1:0]        stk_right;
    logic [DW-1:0]        depth_m1;
    logic [RIGHT_MAX-1:0] cand;
    logic [RIGHT_MAX-1:0] pick_onehot;
    logic [RW-1:0]        pick_idx;
    logic                 row_ok;

    // candidate set and lowest-index pick
    assign cand = adj_rdata & mask_reg & ~visited_reg;

    always_comb
    begin
        pick_idx = '0;
        for (int i = RIGHT_MAX - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                pick_idx = RW'(i);
            end
        end
    end

    assign pick_onehot = RIGHT_MAX'(1) << pick_idx;
    assign row_ok      = (rows_reg < RLW'(LEFT_MAX));
    assign stk_left    = stk_rdata[SW-1:RW];
    assign stk_right   = stk_rdata[RW-1:0];
    assign depth_m1    = depth_reg - 1'b1;

    // status to controller
    always_comb
    begin
        sts            = '0;
        sts.row_ok     = row_ok;
        sts.last_pend  = last_reg;
        sts.cand_any   = |cand;
        sts.cand_free  = !pvalid_reg[pick_idx];
        sts.depth_zero = (depth_reg == '0);
        sts.res_busy   = res_valid_reg && !res_ready;
    end

    // adjacency rows, one per left vertex
    assign adj_raddr = cmd.follow   ? part_rdata :
                       cmd.pop_take ? stk_left   : cur_reg;

    bmm_ram #(
        .WIDTH (RIGHT_MAX),
        .DEPTH (LEFT_MAX)
    ) u_adj_ram (
        .clk   (clk),
        .we    (cmd.accept && row_ok),
        .waddr (rows_reg[LW-1:0]),
        .wdata (row_item.row_bits[RIGHT_MAX-1:0]),
        .re    (cmd.read_adj || cmd.follow || cmd.pop_take),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // left partner of each right vertex
    assign part_we    = cmd.claim || cmd.unwind_wr;
    assign part_waddr = cmd.claim ? pick_idx : stk_right;
    assign part_wdata = cmd.claim ? cur_reg  : stk_left;

    bmm_ram #(
        .WIDTH (LW),
        .DEPTH (RIGHT_MAX)
    ) u_part_ram (
        .clk   (clk),
        .we    (part_we),
        .waddr (part_waddr),
        .wdata (part_wdata),
        .re    (cmd.push),
        .raddr (pick_idx),
        .rdata (part_rdata)
    );

    // search stack of (left vertex, right vertex) frames
    bmm_ram #(
        .WIDTH (SW),
        .DEPTH (RIGHT_MAX)
    ) u_stk_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (depth_reg[RW-1:0]),
        .wdata ({cur_reg, pick_idx}),
        .re    (cmd.pop_read),
        .raddr (depth_m1[RW-1:0]),
        .rdata (stk_rdata)
    );

    // active right vertex mask from right_count
    always_comb
    begin
        mask_next = mask_reg;
        if (cfg_valid)
        begin
            for (int i = 0; i < RIGHT_MAX; i++)
            begin
                mask_next[i] = (CNT_W'(i) < cfg_data);
            end
        end
    end

    // search and graph state updates
    always_comb
    begin
        rows_next      = rows_reg;
        cur_next       = cur_reg;
        depth_next     = depth_reg;
        visited_next   = visited_reg;
        pvalid_next    = pvalid_reg;
        matched_next   = matched_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        res_valid_next = res_valid_reg && !res_ready;

        if (cmd.accept)
        begin
            last_next    = row_item.last_row;
            visited_next = '0;
            depth_next   = '0;
            if (row_ok)
            begin
                rows_next = rows_reg + 1'b1;
                cur_next  = rows_reg[LW-1:0];
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.take_edge)
        begin
            visited_next = visited_reg | pick_onehot;
        end
        if (cmd.claim)
        begin
            pvalid_next[pick_idx] = 1'b1;
            matched_next          = matched_reg + 1'b1;
        end
        if (cmd.push)
        begin
            depth_next = depth_reg + 1'b1;
        end
        if (cmd.pop_read)
        begin
            depth_next = depth_m1;
        end
        if (cmd.follow)
        begin
            cur_next = part_rdata;
        end
        if (cmd.pop_take)
        begin
            cur_next = stk_left;
        end
        if (cmd.emit)
        begin
            res_valid_next = 1'b1;
            rows_next      = '0;
            visited_next   = '0;
            pvalid_next    = '0;
            matched_next   = '0;
            ovf_next       = 1'b0;
            last_next      = 1'b0;
        end
    end

    // control registers, right_count resets to 64 so every right vertex is in use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '1;
            rows_reg      <= '0;
            depth_reg     <= '0;
            visited_reg   <= '0;
            pvalid_reg    <= '0;
            matched_reg   <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            rows_reg      <= rows_next;
            depth_reg     <= depth_next;
            visited_reg   <= visited_next;
            pvalid_reg    <= pvalid_next;
            matched_reg   <= matched_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cmd.emit)
        begin
            res_item_reg.match_count <= matched_reg;
            res_item_reg.overflow    <= ovf_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

FILE: hdl/bipartite_max_matching_top.sv
// top level of the maximum bipartite matching block
//
//  channel | signals                        | item
//  --------+--------------------------------+------------------------------------
//  row     | row_valid, row_ready, row_item | adjacency row of one left vertex
//  res     | res_valid, res_ready, res_item | matching size and overflow flag
//  cfg     | cfg_valid, cfg_ready, cfg_data | right_count write, always ready
//
// one row is processed at a time: the row is taken and its adjacency read, then the
// search steps forward or back, rewrites each partner along the augmenting path and
// finishes, walking the adjacency, partner and stack memories, which have one read
// port each. a row beyond LEFT_MAX skips the search and sets the overflow flag.
// reset needs no clearing pass.
// a waiting result does not block new rows; the block stalls only when a
// last row finishes while the previous result has not been taken.
`default_nettype none

module bipartite_max_matching_top
    import bmm_pkg::*;
#(
    parameter int LEFT_MAX  = 64,
    parameter int RIGHT_MAX = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             row_valid,
    output logic                  row_ready,
    input  wire row_item_t        row_item,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output res_item_t             res_item,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // controller
    bmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath
    bmm_datapath #(
        .LEFT_MAX  (LEFT_MAX),
        .RIGHT_MAX (RIGHT_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .row_item  (row_item),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    // one row at a time: no second row in the cycle after one is taken
    a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
        (row_valid && row_ready) |=> !row_ready)
        else $error("row taken while previous row in progress");

    // stack must be empty whenever a new row can be taken
    a_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        row_ready |-> sts.depth_zero)
        else $error("search stack not empty at idle");

    // a matching never exceeds the right vertex count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.match_count <= CNT_W'(RIGHT_MAX)))
        else $error("match count out of range");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// self-checking testbench for the bipartite matching block against a matching predictor
`timescale 1ns / 1ps

module tb_top
    import bmm_pkg::*;
();

    localparam int CLK_PERIOD    = 12;
    localparam int LEFT_ROWS     = 64;
    localparam int RIGHT_COLS    = 64;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_CYCLES   = 3000;
    localparam int LIMIT_CYCLES  = 2_500_000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             row_valid = 1'b0;
    logic             row_ready;
    row_item_t        row_item  = '0;
    logic             res_valid;
    logic             res_ready = 1'b0;
    res_item_t        res_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data  = '0;

    // pending input items and expected matching sizes
    row_item_t   row_queue[$];
    res_item_t   expected_sizes[$];
    int unsigned items_queued = 0;
    int unsigned errors       = 0;
    bit          row_gaps_on  = 1'b1;
    bit          res_gaps_on  = 1'b1;
    int unsigned hold_orders  = 0;

    // predictor state for the graph being loaded
    logic [ROW_W-1:0] adj_rows  [LEFT_ROWS];
    logic [6:0]       owner_of  [RIGHT_COLS];
    bit               owned     [RIGHT_COLS];
    logic [6:0]       path_left [RIGHT_COLS];
    logic [5:0]       path_right[RIGHT_COLS];
    logic [63:0]      seen_right;
    int unsigned      rows_in      = 0;
    int unsigned      match_total  = 0;
    bit               rows_dropped = 1'b0;
    logic [CNT_W-1:0] right_limit  = RIGHT_COUNT_RESET;

    bipartite_max_matching_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row_item  (row_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // right vertices in use, clipped to the block size
    function automatic logic [63:0] active_right();
        if (right_limit >= RIGHT_COLS)
            return '1;
        return (64'd1 << right_limit) - 64'd1;
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < RIGHT_COLS; i++)
        begin
            owned[i]    = 1'b0;
            owner_of[i] = '0;
        end
        seen_right   = '0;
        rows_in      = 0;
        match_total  = 0;
        rows_dropped = 1'b0;
    endfunction

    // depth-first augmenting search from one left vertex, lowest right vertex first
    function automatic bit augment_from(int unsigned root);
        logic [63:0] mask;
        logic [63:0] cand;
        int unsigned depth;
        int unsigned cur;
        int unsigned v;
        bit          found;
        bit          done;
        mask       = active_right();
        depth      = 0;
        cur        = root;
        found      = 1'b0;
        done       = 1'b0;
        seen_right = '0;
        while (!done)
        begin
            cand = adj_rows[cur % LEFT_ROWS] & mask & ~seen_right;
            if (cand == '0)
            begin
                // dead end: back up one level or give up at the root
                if (depth == 0)
                    done = 1'b1;
                else
                begin
                    depth--;
                    cur = path_left[depth % RIGHT_COLS];
                end
            end
            else
            begin
                v = 0;
                while (!cand[v])
                    v++;
                seen_right[v] = 1'b1;
                if (!owned[v])
                begin
                    // free vertex: flip the partners along the path
                    owner_of[v] = cur[6:0];
                    owned[v]    = 1'b1;
                    while (depth > 0)
                    begin
                        depth--;
                        owner_of[path_right[depth % RIGHT_COLS]] = path_left[depth % RIGHT_COLS];
                    end
                    found = 1'b1;
                    done  = 1'b1;
                end
                else
                begin
                    path_left[depth % RIGHT_COLS]  = cur[6:0];
                    path_right[depth % RIGHT_COLS] = v[5:0];
                    depth++;
                    cur = owner_of[v];
                end
            end
        end
        return found;
    endfunction

    // apply one accepted item, queue the expected result on the last row
    function automatic void load_row(row_item_t it);
        res_item_t want;
        if (rows_in < LEFT_ROWS)
        begin
            adj_rows[rows_in] = it.row_bits;
            rows_in++;
            if (augment_from(rows_in - 1))
                match_total++;
        end
        else
            rows_dropped = 1'b1;
        if (it.last_row)
        begin
            want.match_count = match_total[CNT_W-1:0];
            want.overflow    = rows_dropped;
            expected_sizes.push_back(want);
            clear_graph();
        end
    endfunction

    // row driver
    always @(posedge clk)
    begin : feed_rows
        row_item_t next_row;
        if (!rst_n)
            row_valid <= 1'b0;
        else
        begin
            if (row_valid && row_ready)
                load_row(row_item);
            if (!row_valid || row_ready)
            begin
                if (row_queue.size() != 0 && !(row_gaps_on && $urandom_range(99) < 20))
                begin
                    next_row = row_queue.pop_front();
                    row_item  <= next_row;
                    row_valid <= 1'b1;
                end
                else
                    row_valid <= 1'b0;
            end
        end
    end

    // result ready with random gaps and long hold-offs on request
    always @(posedge clk)
    begin : drive_ready
        int unsigned hold_left;
        int unsigned holds_started;
        if (!rst_n)
        begin
            res_ready     <= 1'b0;
            hold_left     = 0;
            holds_started = 0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else if (holds_started != hold_orders)
        begin
            holds_started++;
            hold_left = HOLD_CYCLES;
            res_ready <= 1'b0;
        end
        else
            res_ready <= !(res_gaps_on && $urandom_range(99) < 20);
    end

    // result checker
    always @(posedge clk)
    begin : check_results
        res_item_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_sizes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got count %0d overflow %0b",
                         $time, res_item.match_count, res_item.overflow);
                errors++;
            end
            else
            begin
                want = expected_sizes.pop_front();
                if (res_item.match_count !== want.match_count)
                begin
                    $display("%0t: match_count expected %0d, got %0d",
                             $time, want.match_count, res_item.match_count);
                    errors++;
                end
                if (res_item.overflow !== want.overflow)
                begin
                    $display("%0t: overflow expected %0b, got %0b",
                             $time, want.overflow, res_item.overflow);
                    errors++;
                end
            end
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] bit_at(int unsigned pos);
        return 64'd1 << pos;
    endfunction

    function automatic int unsigned used_cols();
        return (right_limit > RIGHT_COLS) ? RIGHT_COLS : right_limit;
    endfunction

    task automatic queue_row(input logic [63:0] bits, input logic last);
        row_item_t it;
        it.row_bits = bits;
        it.last_row = last;
        row_queue.push_back(it);
        items_queued++;
    endtask

    // chain graph whose last row forces one augmenting path through the whole chain
    task automatic queue_chain(input int unsigned r);
        int unsigned n;
        int unsigned off;
        logic [63:0] junk;
        n    = ($urandom_range(3) == 0) ? r - 1 : $urandom_range(1, (r - 1 < 10) ? r - 1 : 10);
        off  = $urandom_range(0, r - 1);
        junk = rand_word() & ~active_right();
        for (int unsigned i = 0; i < n; i++)
            queue_row(bit_at((off + i) % r) | bit_at((off + i + 1) % r) | junk, 1'b0);
        queue_row(bit_at(off) | junk, 1'b1);
    endtask

    // full graph, often with extra rows past the left limit
    task automatic queue_long();
        int unsigned n;
        int unsigned k;
        int unsigned off;
        bit          dense;
        logic [63:0] row;
        n     = LEFT_ROWS + $urandom_range(0, 5);
        k     = 2 * $urandom_range(0, 31) + 1;
        off   = $urandom_range(0, 63);
        dense = ($urandom_range(2) == 0);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (dense)
                row = rand_word() | rand_word();
            else
                row = bit_at((i * k + off) % 64) | (rand_word() & rand_word() & rand_word());
            queue_row(row, i == n - 1);
        end
    endtask

    // small graph with a per-graph density
    task automatic queue_mixed(input int unsigned r);
        int unsigned n;
        int unsigned style;
        logic [63:0] row;
        n     = $urandom_range(1, 12);
        style = $urandom_range(0, 3);
        for (int unsigned i = 0; i < n; i++)
        begin
            case (style)
                0:       row = (r == 0) ? rand_word() : bit_at($urandom_range(0, r - 1))
                               | (rand_word() & rand_word() & rand_word() & rand_word());
                1:       row = rand_word() & rand_word() & rand_word();
                2:       row = rand_word();
                default: row = rand_word() | rand_word();
            endcase
            queue_row(row, i == n - 1);
        end
    endtask

    task automatic queue_random_graph();
        int unsigned shape;
        int unsigned r;
        int unsigned n;
        shape = $urandom_range(0, 99);
        r     = used_cols();
        if (shape < 6)
            queue_long();
        else if (shape < 22 && r >= 2)
            queue_chain(r);
        else if (shape < 30)
        begin
            // rows with no usable edge
            n = $urandom_range(1, 4);
            for (int unsigned i = 0; i < n; i++)
                queue_row(($urandom_range(1) == 0) ? '0 : rand_word() & ~active_right(),
                          i == n - 1);
        end
        else
            queue_mixed(r);
    endtask

    // wait until every item is taken and every result has arrived
    task automatic wait_idle();
        @(posedge clk);
        while (row_queue.size() != 0 || row_valid || expected_sizes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_right_count(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        right_limit = value;
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned target;
        target = items_queued + count;
        while (items_queued < target)
            queue_random_graph();
        wait_idle();
    endtask

    // stimulus
    initial
    begin
        clear_graph();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: single empty and full rows
        queue_row('0, 1'b1);
        queue_row('1, 1'b1);
        // two rows fighting for the top vertex
        queue_row(64'h8000_0000_0000_0000, 1'b0);
        queue_row(64'h8000_0000_0000_0000, 1'b0);
        queue_row(64'h0000_0000_0000_0001, 1'b1);
        // augmenting paths, then a row that fails after a deep search
        queue_row(64'h3, 1'b0);
        queue_row(64'h1, 1'b0);
        queue_row(64'h6, 1'b0);
        queue_row(64'h4, 1'b1);
        // alternating patterns
        queue_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        queue_row(64'h5555_5555_5555_5555, 1'b1);
        // chain shifted by its last row
        for (int i = 0; i < 8; i++)
            queue_row(64'h3 << i, 1'b0);
        queue_row(64'h1, 1'b1);
        wait_idle();

        // sweep of right counts, extremes first
        set_right_count(7'd1);
        random_phase(180);
        set_right_count(7'd0);
        random_phase(60);
        set_right_count(7'd127);
        random_phase(200);
        set_right_count(7'd65);
        random_phase(150);

        // stretch with no gaps on either side
        set_right_count(7'd64);
        row_gaps_on = 1'b0;
        res_gaps_on = 1'b0;
        random_phase(250);

        // long receiver hold-off while one-row graphs keep coming
        hold_orders++;
        for (int i = 0; i < 40; i++)
            queue_row(rand_word() & rand_word(), 1'b1);
        wait_idle();
        row_gaps_on = 1'b1;
        res_gaps_on = 1'b1;

        set_right_count(7'($urandom_range(2, 63)));
        random_phase(250);
        set_right_count(7'd64);
        random_phase(300);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("simulation failed");
        $finish;
    end

endmodule
